FILE: rtl/core/dae_pkg.sv
// Shared types and constants for the dynamic array engine.
// Used by dae_ctrl, dae_dpath and dynamic_array_engine; no dependencies.
`default_nettype none

package dae_pkg;

  localparam int TYPE_W  = 3;
  localparam int IDX_W   = 7;
  localparam int DATA_W  = 32;
  localparam int CNT_O_W = 7;
  localparam int ST_W    = 2;

  typedef enum logic [TYPE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_GET    = 3'd2,
    OP_POP    = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } st_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SHRD = 4'b0100,
    S_SHWR = 4'b1000
  } ctl_state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]        req_type;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [CNT_O_W-1:0]       count_out;
    logic [CNT_O_W-1:0]       capacity_out;
    logic [ST_W-1:0]          status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic load_rd;
    logic sh_rd;
    logic sh_wr;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic need_read;
    logic need_shift;
    logic shift_more;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/dae_ctrl.sv
// Sequencer for the dynamic array engine: input handshake, get read and remove shift.
// Depends on dae_pkg.
`default_nettype none

module dae_ctrl
  import dae_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output ctl_cmd_t        cmd_o
);

  ctl_state_e state_q, state_d;
  logic       accept;

  assign in_stall_o = !((state_q == S_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.exec = 1'b1;
          if (status_i.need_read) begin
            state_d = S_READ;
          end else if (status_i.need_shift) begin
            state_d = S_SHRD;
          end
        end
      end
      S_READ: begin
        cmd_o.load_rd = 1'b1;
        state_d       = S_IDLE;
      end
      S_SHRD: begin
        cmd_o.sh_rd = 1'b1;
        state_d     = S_SHWR;
      end
      S_SHWR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = status_i.shift_more ? S_SHRD : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_shift_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sh_rd |=> cmd_o.sh_wr)
    else $error("shift read not followed by shift write");

  a_load_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_rd |-> $past(cmd_o.exec))
    else $error("read load without a preceding get");

  a_busy_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (in_stall_o && !cmd_o.exec))
    else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dae_dpath.sv
// Datapath for the dynamic array engine: element store, count, capacity,
// shift pointer and result register. Depends on dae_pkg.
`default_nettype none

module dae_dpath
  import dae_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ctl_cmd_t cmd_i,
  input  wire req_t     req_i,
  input  wire logic     out_stall_i,
  output dp_status_t    status_o,
  output logic          out_valid_o,
  output rsp_t          out_rsp_o
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q, cap_q;
  logic [AW-1:0]    ptr_q;
  logic             out_valid_q;
  rsp_t             rsp_q;

  logic [CW:0] idx_x, cnt_x, cap_x, cnt_n, cap_n, grown, grown_c;
  logic        full, at_max, app, do_wr, is_get, is_shift;
  st_e         st;
  logic [AW-1:0] wr_addr, mem_waddr, mem_raddr;
  logic [WIDTH-1:0] mem_wdata, req_wdata;
  logic [WIDTH+DATA_W-1:0] wd_ext, rd_ext;
  logic [CNT_W:0] ptr_next;
  logic mem_we, mem_re;

  assign idx_x   = (CW + 1)'(req_i.index);
  assign cnt_x   = (CW + 1)'(cnt_q);
  assign cap_x   = (CW + 1)'(cap_q);
  assign full    = cnt_x >= cap_x;
  assign at_max  = cap_x >= DEPTH_C;
  assign grown   = cap_x << 1;
  assign grown_c = (grown > DEPTH_C) ? DEPTH_C : grown;

  always_comb begin
    cnt_n    = cnt_x;
    cap_n    = cap_x;
    st       = ST_OK;
    app      = 1'b0;
    do_wr    = 1'b0;
    wr_addr  = idx_x[AW-1:0];
    is_get   = 1'b0;
    is_shift = 1'b0;
    case (req_i.req_type)
      OP_PUSH: begin
        app = 1'b1;
      end
      OP_WRITE: begin
        if (idx_x < cap_x) begin
          do_wr = 1'b1;
        end else if (idx_x == cap_x) begin
          app = 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      OP_GET: begin
        if (idx_x < cnt_x) begin
          is_get = 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      OP_POP: begin
        if (cnt_x == '0) begin
          st = ST_EMPTY;
        end else begin
          cnt_n = cnt_x - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (idx_x < cnt_x) begin
          cnt_n    = cnt_x - 1'b1;
          is_shift = (idx_x + 1'b1) < cnt_x;
        end else begin
          st = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    // append: grow when full, refuse once the store is at its limit
    if (app) begin
      if (full && at_max) begin
        st = ST_FULL;
      end else begin
        if (full) begin
          cap_n = grown_c;
        end
        do_wr   = 1'b1;
        wr_addr = cnt_q[AW-1:0];
        cnt_n   = cnt_x + 1'b1;
      end
    end
  end

  assign ptr_next = (CNT_W + 1)'(ptr_q) + 1'b1;
  assign wd_ext   = {{WIDTH{1'b0}}, req_i.data};
  assign req_wdata = wd_ext[WIDTH-1:0];
  assign rd_ext   = {{DATA_W{1'b0}}, rd_q};

  assign mem_we    = (cmd_i.exec && do_wr) || cmd_i.sh_wr;
  assign mem_waddr = cmd_i.sh_wr ? ptr_q : wr_addr;
  assign mem_wdata = cmd_i.sh_wr ? rd_q : req_wdata;
  assign mem_re    = (cmd_i.exec && is_get) || cmd_i.sh_rd;
  assign mem_raddr = cmd_i.sh_rd ? ptr_next[AW-1:0] : idx_x[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= CNT_W'(1);
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_n[CNT_W-1:0];
      cap_q <= cap_n[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ptr_q <= idx_x[AW-1:0];
    end else if (cmd_i.sh_wr) begin
      ptr_q <= ptr_next[AW-1:0];
    end
  end

  // result register: loaded at accept, or in the cycle after accept for a get
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.exec && !is_get) || cmd_i.load_rd) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !is_get) begin
      rsp_q.read_data    <= '0;
      rsp_q.count_out    <= cnt_n[CNT_O_W-1:0];
      rsp_q.capacity_out <= cap_n[CNT_O_W-1:0];
      rsp_q.status       <= st;
    end else if (cmd_i.load_rd) begin
      rsp_q.read_data    <= rd_ext[DATA_W-1:0];
      rsp_q.count_out    <= cnt_x[CNT_O_W-1:0];
      rsp_q.capacity_out <= cap_x[CNT_O_W-1:0];
      rsp_q.status       <= ST_OK;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.need_read  = is_get;
  assign status_o.need_shift = is_shift;
  assign status_o.shift_more = ptr_next < (CNT_W + 1)'(cnt_q);

`ifndef ASSERT_OFF
  a_cnt_le_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cap_q)
    else $error("count above capacity");

  a_cap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && ((CW + 1)'(cap_q) <= DEPTH_C))
    else $error("capacity out of range");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_rd |-> !out_valid_q)
    else $error("read result overwrites a waiting beat");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dynamic_array_engine.sv
// Push, pop, write and spare codes: result in the cycle after accept, one request a cycle
// while the output is not stalled. Get: the element is read at accept and reaches the
// result register in the read state. Remove: result in the cycle after accept; then each
// later element moves down by one read and one write. No request is taken in either wait.
// Reset clears count to zero and capacity to one; the element store is not cleared.
// Top level; depends on dae_pkg, dae_ctrl and dae_dpath.
`default_nettype none

module dynamic_array_engine
  import dae_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_rsp_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  dae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dae_dpath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for dynamic_array_engine: push, indexed write, get, pop and remove.
// Depends on dae_pkg and the engine RTL; a behavioural vector model predicts every response.
`default_nettype none

module tb_top;
  import dae_pkg::*;

  localparam int VEC_DEPTH   = 64;
  localparam int RAND_ITEMS  = 550;
  localparam int PARK_CYCLES = 90;
  localparam int TAIL_CYCLES = 2 * VEC_DEPTH + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_LIMIT  = 40;

  localparam logic [TYPE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [TYPE_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  // vector model state
  logic [DATA_W-1:0] vec_mem [VEC_DEPTH];
  int vec_count = 0;
  int vec_cap = 1;
  int vec_peak = 0;

  req_t stim_q [$];
  rsp_t resp_q [$];
  int queued_total = 0;
  int accepted_total = 0;
  int fail_cnt = 0;
  int shown_cnt = 0;
  int cycle_cnt = 0;
  int op_hits [8];
  int st_hits [4];

  int gap_left = 0;
  int stall_left = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  int park_req = 0;
  int park_seen = 0;
  int park_left = 0;

  dynamic_array_engine #(
    .DEPTH(VEC_DEPTH),
    .WIDTH(DATA_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [ST_W-1:0] vec_append(logic [DATA_W-1:0] value);
    if (vec_count >= vec_cap) begin
      if (vec_cap >= VEC_DEPTH) return ST_FULL;
      vec_cap = (vec_cap * 2 > VEC_DEPTH) ? VEC_DEPTH : vec_cap * 2;
    end
    vec_mem[vec_count] = value;
    vec_count++;
    if (vec_count > vec_peak) vec_peak = vec_count;
    return ST_OK;
  endfunction

  function automatic rsp_t vec_apply(req_t r);
    rsp_t res;
    int idx;
    res = '0;
    res.status = ST_OK;
    idx = int'(r.index);
    case (r.req_type)
      OP_PUSH: res.status = vec_append(r.data);
      OP_WRITE: begin
        if (idx < vec_cap) vec_mem[idx] = r.data;
        else if (idx == vec_cap) res.status = vec_append(r.data);
        else res.status = ST_RANGE;
      end
      OP_GET: begin
        if (idx < vec_count) res.read_data = vec_mem[idx];
        else res.status = ST_RANGE;
      end
      OP_POP: begin
        if (vec_count == 0) res.status = ST_EMPTY;
        else vec_count--;
      end
      OP_REMOVE: begin
        if (idx < vec_count) begin
          for (int i = idx; i + 1 < vec_count; i++) vec_mem[i] = vec_mem[i + 1];
          vec_count--;
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    res.count_out    = vec_count[CNT_O_W-1:0];
    res.capacity_out = vec_cap[CNT_O_W-1:0];
    op_hits[r.req_type]++;
    st_hits[res.status]++;
    return res;
  endfunction

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic note_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    fail_cnt++;
    if (shown_cnt < SHOW_LIMIT)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    else if (shown_cnt == SHOW_LIMIT)
      $display("%0t: further mismatches not shown", $time);
    shown_cnt++;
  endtask

  // driver: hold a stalled beat, otherwise fetch the next pending request after its gap
  always @(posedge clk_i) begin
    logic nxt_valid;
    req_t nxt_req;
    nxt_valid = in_valid;
    nxt_req = in_req;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        resp_q = {resp_q, vec_apply(in_req)};
        accepted_total++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          nxt_req = stim_q.pop_front();
          nxt_valid = 1'b1;
          gap_left = steady_in ? 0 : idle_len();
        end
      end
    end
    in_valid <= nxt_valid;
    in_req <= nxt_req;
  end

  // monitor: check each accepted response beat and drive the stall pattern
  always @(posedge clk_i) begin
    rsp_t want;
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: response beat with nothing expected, got %0h", $time, out_rsp);
        end else begin
          want = resp_q.pop_front();
          if (out_rsp.read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, out_rsp.read_data);
          if (out_rsp.count_out !== want.count_out)
            note_mismatch("count_out", DATA_W'(want.count_out), DATA_W'(out_rsp.count_out));
          if (out_rsp.capacity_out !== want.capacity_out)
            note_mismatch("capacity_out", DATA_W'(want.capacity_out),
                          DATA_W'(out_rsp.capacity_out));
          if (out_rsp.status !== want.status)
            note_mismatch("status", DATA_W'(want.status), DATA_W'(out_rsp.status));
        end
      end
      if (park_seen != park_req) begin
        park_seen = park_req;
        park_left = PARK_CYCLES;
      end
      if (park_left > 0) begin
        park_left--;
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!steady_out && $urandom_range(0, 99) < 30) begin
        stall_left = idle_len();
        nxt_stall = 1'b1;
      end
    end
    out_stall <= nxt_stall;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d responses outstanding", $time, resp_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_req(logic [TYPE_W-1:0] op, int idx, logic [DATA_W-1:0] value);
    req_t r;
    r.req_type = op;
    r.index = idx[IDX_W-1:0];
    r.data = value;
    stim_q = {stim_q, r};
    queued_total++;
  endtask

  task automatic settle_accept();
    while (accepted_total != queued_total) @(posedge clk_i);
  endtask

  task automatic settle_all();
    settle_accept();
    while (resp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_slot(int limit);
    if (limit > 0 && $urandom_range(0, 99) < 75) return $urandom_range(0, limit - 1);
    return $urandom_range(limit, 127);
  endfunction

  initial begin
    int made;
    int batch;
    int phase;
    int r;
    int c;
    int k;
    bit parked;
    bit paused;
    logic [TYPE_W-1:0] op;
    made = 0;
    parked = 1'b0;
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty refusals, growth, write around capacity, reads, shift, spare codes
    queue_req(OP_GET, 0, '0);
    queue_req(OP_POP, 0, '0);
    queue_req(OP_REMOVE, 0, '0);
    queue_req(OP_PUSH, 0, 32'h7fff_ffff);
    queue_req(OP_PUSH, 0, 32'h8000_0000);
    queue_req(OP_WRITE, 2, 32'hffff_ffff);
    queue_req(OP_WRITE, 3, 32'h1234_5678);
    queue_req(OP_WRITE, 5, 32'h0bad_0bad);
    queue_req(OP_WRITE, 127, 32'h5555_aaaa);
    queue_req(OP_GET, 0, '0);
    queue_req(OP_GET, 1, '0);
    queue_req(OP_GET, 2, '0);
    queue_req(OP_GET, 3, '0);
    queue_req(OP_GET, 127, '0);
    queue_req(OP_REMOVE, 0, '0);
    queue_req(OP_REMOVE, 5, '0);
    queue_req(OP_SPARE_LO, 1, 32'hdead_beef);
    queue_req(OP_SPARE_HI, 127, '1);
    queue_req(OP_WRITE, 0, '0);
    queue_req(OP_GET, 0, '0);
    queue_req(OP_POP, 0, '0);
    queue_req(OP_POP, 0, '0);
    queue_req(OP_POP, 0, '0);
    settle_all();

    // random batches, shaped by the predicted fill so indexes mostly land in range
    while (made < RAND_ITEMS) begin
      settle_accept();
      c = vec_count;
      k = vec_cap;
      steady_in = ($urandom_range(0, 5) == 0);
      steady_out = ($urandom_range(0, 5) == 0);
      if (!parked && made >= 150) begin
        // hold the receiver while a dense batch keeps the input busy
        parked = 1'b1;
        steady_in = 1'b1;
        park_req++;
      end
      if (!paused && made >= 350) begin
        paused = 1'b1;
        settle_all();
      end
      r = $urandom_range(0, 9);
      phase = (c <= 4 || r < 4) ? 0 : (r < 7) ? 1 : 2;
      batch = $urandom_range(8, 20);
      for (int n = 0; n < batch; n++) begin
        r = $urandom_range(0, 99);
        case (phase)
          0: op = (r < 50) ? OP_PUSH : (r < 70) ? OP_WRITE : (r < 85) ? OP_GET :
                  (r < 90) ? OP_REMOVE : (r < 96) ? OP_POP : OP_SPARE_LO;
          1: op = (r < 25) ? OP_PUSH : (r < 45) ? OP_WRITE : (r < 65) ? OP_GET :
                  (r < 80) ? OP_REMOVE : (r < 95) ? OP_POP : OP_SPARE_LO;
          default: op = (r < 10) ? OP_PUSH : (r < 15) ? OP_WRITE : (r < 30) ? OP_GET :
                        (r < 60) ? OP_REMOVE : (r < 96) ? OP_POP : OP_SPARE_LO;
        endcase
        if (op == OP_SPARE_LO) op = TYPE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        case (op)
          OP_WRITE:
            queue_req(op, ($urandom_range(0, 99) < 80) ? $urandom_range(0, k)
                                                       : $urandom_range(0, 127), pick_data());
          OP_GET, OP_REMOVE: queue_req(op, pick_slot(c), $urandom);
          default: queue_req(op, $urandom_range(0, 127), pick_data());
        endcase
      end
      made += batch;
    end

    settle_all();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: push %0d, write %0d, get %0d, pop %0d, remove %0d, spare %0d",
             accepted_total, op_hits[OP_PUSH], op_hits[OP_WRITE], op_hits[OP_GET],
             op_hits[OP_POP], op_hits[OP_REMOVE],
             op_hits[5] + op_hits[6] + op_hits[7]);
    $display("Outcomes: ok %0d, full %0d, range %0d, empty %0d; peak fill %0d",
             st_hits[ST_OK], st_hits[ST_FULL], st_hits[ST_RANGE], st_hits[ST_EMPTY], vec_peak);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
